/* src/dsm_pkg.sv */
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared widths, constants and inter-stage types of the differential
// steering mixer.
// ----------------------------------------------------------------------------
package dsm_pkg;

    // full-scale pwm duty
    localparam int DUTY_MAX = 1023;
    localparam int DUTY_W   = 10;

    // field widths
    localparam int JOY_W    = 8;
    localparam int LIMIT_W  = 7;
    localparam int LEVEL_W  = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;

    // premix and blend arithmetic
    localparam int PREMIX_W = 9;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = 24;
    localparam int NUM_W    = 23;
    localparam int DEN_W    = 14;

    // divider: two quotient bits per stage
    localparam int QUO_W      = 8;
    localparam int DIV_STAGES = QUO_W / 2;

    // shaping arithmetic
    localparam int REMAP_P_W = QUO_W + LEVEL_W;
    localparam int MIX_W     = 12;
    localparam int MAG_W     = 11;

    // reset values of the configuration registers
    localparam logic [LIMIT_W-1:0] PIVOT_LIMIT_RST    = 7'd32;
    localparam logic [LEVEL_W-1:0] MOVE_THRESHOLD_RST = 10'd128;
    localparam logic [LEVEL_W-1:0] MIN_SPEED_RST      = 10'd768;

    // premix base level
    localparam logic signed [PREMIX_W-1:0] PREMIX_BASE = 9'sd99;

    // percent scaling of the blend and of the duty
    localparam logic [DEN_W-1:0] PERCENT = 14'd100;

    // magnitude at and above which the duty saturates
    localparam logic [MAG_W-1:0] SAT_MAG = 11'd101;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIVOT_LIMIT    = 2'd0,
        CFG_MOVE_THRESHOLD = 2'd1,
        CFG_MIN_SPEED      = 2'd2
    } cfg_index_t;

    // signed numerator as sign and magnitude, with its divisor
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    // truncated quotient as sign and magnitude
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

    // one motor command
    typedef struct packed {
        logic              valid;
        logic              reverse;
        logic [DUTY_W-1:0] duty;
    } motor_cmd_t;

endpackage

/* src/dsm_front.sv */
// ----------------------------------------------------------------------------
// dsm_front
// Premix selection, blend weight and the signed blend numerators for both
// sides, in five register stages.
// ----------------------------------------------------------------------------
module dsm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [dsm_pkg::JOY_W-1:0]   joy_x,
    input  logic signed [dsm_pkg::JOY_W-1:0]   joy_y,
    input  logic [dsm_pkg::LIMIT_W-1:0]        pivot_limit,
    output dsm_pkg::div_req_t                  left_req,
    output dsm_pkg::div_req_t                  right_req
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg;

    // stage 1: premix by quadrant and blend weight
    logic [dsm_pkg::JOY_W-1:0]                  abs_y;
    logic signed [dsm_pkg::PREMIX_W-1:0]        x_ext;
    logic signed [dsm_pkg::JOY_W-1:0]           x1_reg, y1_reg;
    logic signed [dsm_pkg::PREMIX_W-1:0]        pl1_reg, pl1_next, pr1_reg, pr1_next;
    logic [dsm_pkg::LIMIT_W-1:0]                a1_reg, a1_next;

    always_comb
    begin
        abs_y = joy_y[dsm_pkg::JOY_W-1] ? (~joy_y + 8'sd1) : joy_y;
        x_ext = {joy_x[dsm_pkg::JOY_W-1], joy_x};
        if (abs_y < {1'b0, pivot_limit})
        begin
            a1_next = abs_y[dsm_pkg::LIMIT_W-1:0];
        end
        else
        begin
            a1_next = pivot_limit;
        end
        if (!joy_y[dsm_pkg::JOY_W-1])
        begin
            pl1_next = joy_x[dsm_pkg::JOY_W-1] ? dsm_pkg::PREMIX_BASE + x_ext
                                               : dsm_pkg::PREMIX_BASE;
            pr1_next = joy_x[dsm_pkg::JOY_W-1] ? dsm_pkg::PREMIX_BASE
                                               : dsm_pkg::PREMIX_BASE - x_ext;
        end
        else
        begin
            pl1_next = joy_x[dsm_pkg::JOY_W-1] ? dsm_pkg::PREMIX_BASE
                                               : dsm_pkg::PREMIX_BASE - x_ext;
            pr1_next = joy_x[dsm_pkg::JOY_W-1] ? dsm_pkg::PREMIX_BASE + x_ext
                                               : dsm_pkg::PREMIX_BASE;
        end
    end

    // stage 2: weighted premix, pivot weight and divisor
    logic                                       lim_zero;
    logic signed [dsm_pkg::WEIGHT_W-1:0]        a_s, pl_s, pr_s;
    logic signed [dsm_pkg::WEIGHT_W-1:0]        tl2_reg, tl2_next, tr2_reg, tr2_next;
    logic [dsm_pkg::DEN_W-1:0]                  c2_reg, c2_next, den2_reg, den2_next;
    logic [dsm_pkg::LIMIT_W-1:0]                lim_gap;
    logic signed [dsm_pkg::JOY_W-1:0]           x2_reg, y2_reg;

    always_comb
    begin
        lim_zero = (pivot_limit == '0);
        lim_gap  = pivot_limit - a1_reg;
        a_s      = {{(dsm_pkg::WEIGHT_W-dsm_pkg::LIMIT_W){1'b0}}, a1_reg};
        pl_s     = {{(dsm_pkg::WEIGHT_W-dsm_pkg::PREMIX_W){pl1_reg[dsm_pkg::PREMIX_W-1]}},
                    pl1_reg};
        pr_s     = {{(dsm_pkg::WEIGHT_W-dsm_pkg::PREMIX_W){pr1_reg[dsm_pkg::PREMIX_W-1]}},
                    pr1_reg};
        if (lim_zero)
        begin
            // no pivot blend: plain throttle over one percent
            tl2_next  = pl_s;
            tr2_next  = pr_s;
            c2_next   = '0;
            den2_next = dsm_pkg::PERCENT;
        end
        else
        begin
            tl2_next  = a_s * pl_s;
            tr2_next  = a_s * pr_s;
            c2_next   = {{(dsm_pkg::DEN_W-dsm_pkg::LIMIT_W){1'b0}}, lim_gap}
                        * dsm_pkg::PERCENT;
            den2_next = {{(dsm_pkg::DEN_W-dsm_pkg::LIMIT_W){1'b0}}, pivot_limit}
                        * dsm_pkg::PERCENT;
        end
    end

    // stage 3: throttle and pivot products
    logic signed [dsm_pkg::PROD_W-1:0]          y_s, x_s, c_s, tl_s, tr_s;
    logic signed [dsm_pkg::PROD_W-1:0]          ml3_reg, ml3_next, mr3_reg, mr3_next;
    logic signed [dsm_pkg::PROD_W-1:0]          pv3_reg, pv3_next;
    logic [dsm_pkg::DEN_W-1:0]                  den3_reg;

    always_comb
    begin
        y_s  = {{(dsm_pkg::PROD_W-dsm_pkg::JOY_W){y2_reg[dsm_pkg::JOY_W-1]}}, y2_reg};
        x_s  = {{(dsm_pkg::PROD_W-dsm_pkg::JOY_W){x2_reg[dsm_pkg::JOY_W-1]}}, x2_reg};
        c_s  = {{(dsm_pkg::PROD_W-dsm_pkg::DEN_W){1'b0}}, c2_reg};
        tl_s = {{(dsm_pkg::PROD_W-dsm_pkg::WEIGHT_W){tl2_reg[dsm_pkg::WEIGHT_W-1]}}, tl2_reg};
        tr_s = {{(dsm_pkg::PROD_W-dsm_pkg::WEIGHT_W){tr2_reg[dsm_pkg::WEIGHT_W-1]}}, tr2_reg};
        ml3_next = tl_s * y_s;
        mr3_next = tr_s * y_s;
        pv3_next = c_s * x_s;
    end

    // stage 4: blend sums, pivot is +x on the left and -x on the right
    logic signed [dsm_pkg::PROD_W-1:0]          nl4_reg, nl4_next, nr4_reg, nr4_next;
    logic [dsm_pkg::DEN_W-1:0]                  den4_reg;

    always_comb
    begin
        nl4_next = ml3_reg + pv3_reg;
        nr4_next = mr3_reg - pv3_reg;
    end

    // stage 5: sign and magnitude for the divider
    logic [dsm_pkg::PROD_W-1:0]                 abs_l, abs_r;
    logic                                       negl5_reg, negr5_reg;
    logic [dsm_pkg::NUM_W-1:0]                  magl5_reg, magr5_reg;
    logic [dsm_pkg::DEN_W-1:0]                  den5_reg;

    always_comb
    begin
        abs_l = nl4_reg[dsm_pkg::PROD_W-1] ? 24'(-nl4_reg) : 24'(nl4_reg);
        abs_r = nr4_reg[dsm_pkg::PROD_W-1] ? 24'(-nr4_reg) : 24'(nr4_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        x1_reg    <= joy_x;
        y1_reg    <= joy_y;
        pl1_reg   <= pl1_next;
        pr1_reg   <= pr1_next;
        a1_reg    <= a1_next;

        x2_reg    <= x1_reg;
        y2_reg    <= y1_reg;
        tl2_reg   <= tl2_next;
        tr2_reg   <= tr2_next;
        c2_reg    <= c2_next;
        den2_reg  <= den2_next;

        ml3_reg   <= ml3_next;
        mr3_reg   <= mr3_next;
        pv3_reg   <= pv3_next;
        den3_reg  <= den2_reg;

        nl4_reg   <= nl4_next;
        nr4_reg   <= nr4_next;
        den4_reg  <= den3_reg;

        negl5_reg <= nl4_reg[dsm_pkg::PROD_W-1];
        negr5_reg <= nr4_reg[dsm_pkg::PROD_W-1];
        magl5_reg <= abs_l[dsm_pkg::NUM_W-1:0];
        magr5_reg <= abs_r[dsm_pkg::NUM_W-1:0];
        den5_reg  <= den4_reg;
    end

    // requests to the dividers
    always_comb
    begin
        left_req.valid  = vld_reg[STAGES-1];
        left_req.neg    = negl5_reg;
        left_req.num    = magl5_reg;
        left_req.den    = den5_reg;
        right_req.valid = vld_reg[STAGES-1];
        right_req.neg   = negr5_reg;
        right_req.num   = magr5_reg;
        right_req.den   = den5_reg;
    end

endmodule

/* src/dsm_divider.sv */
// ----------------------------------------------------------------------------
// dsm_divider
// Pipelined restoring divider on magnitudes: two quotient bits per stage,
// quotient known to stay below 2**QUO_W.
// ----------------------------------------------------------------------------
module dsm_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  dsm_pkg::div_req_t  req,
    output dsm_pkg::div_rsp_t  rsp
);

    localparam int LAST = dsm_pkg::DIV_STAGES - 1;

    logic                          vld_reg [dsm_pkg::DIV_STAGES];
    logic                          neg_reg [dsm_pkg::DIV_STAGES];
    logic [dsm_pkg::QUO_W-1:0]     quo_reg [dsm_pkg::DIV_STAGES];
    logic [dsm_pkg::NUM_W-1:0]     rem_reg [LAST];
    logic [dsm_pkg::DEN_W-1:0]     den_reg [LAST];

    for (genvar s = 0; s < dsm_pkg::DIV_STAGES; s++)
    begin : g_stage
        localparam int HI = dsm_pkg::QUO_W - 1 - 2 * s;

        logic                      vld_in, neg_in;
        logic [dsm_pkg::NUM_W-1:0] rem_in, rem_mid, rem_out, sh_hi, sh_lo, den_ext;
        logic [dsm_pkg::DEN_W-1:0] den_in;
        logic [dsm_pkg::QUO_W-1:0] quo_in, quo_next;

        // stage input from the request or the previous stage
        if (s == 0)
        begin : g_first
            assign vld_in = req.valid;
            assign neg_in = req.neg;
            assign rem_in = req.num;
            assign den_in = req.den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[s-1];
            assign neg_in = neg_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        // two compare-subtract steps
        always_comb
        begin
            den_ext  = {{(dsm_pkg::NUM_W-dsm_pkg::DEN_W){1'b0}}, den_in};
            sh_hi    = den_ext << HI;
            sh_lo    = den_ext << (HI - 1);
            quo_next = quo_in;
            if (rem_in >= sh_hi)
            begin
                rem_mid      = rem_in - sh_hi;
                quo_next[HI] = 1'b1;
            end
            else
            begin
                rem_mid = rem_in;
            end
            if (rem_mid >= sh_lo)
            begin
                rem_out          = rem_mid - sh_lo;
                quo_next[HI - 1] = 1'b1;
            end
            else
            begin
                rem_out = rem_mid;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            neg_reg[s] <= neg_in;
            quo_reg[s] <= quo_next;
        end

        // the last stage carries no remainder or divisor on
        if (s < LAST)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_out;
                den_reg[s] <= den_in;
            end
        end
    end

    always_comb
    begin
        rsp.valid = vld_reg[LAST];
        rsp.neg   = neg_reg[LAST];
        rsp.quo   = quo_reg[LAST];
    end

endmodule

/* src/dsm_shaper.sv */
// ----------------------------------------------------------------------------
// dsm_shaper
// Minimum-speed remap, percent-to-duty scaling and saturation for one side,
// in four register stages.
// ----------------------------------------------------------------------------
module dsm_shaper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsm_pkg::div_rsp_t             mix,
    input  logic [dsm_pkg::LEVEL_W-1:0]   move_threshold,
    input  logic [dsm_pkg::LEVEL_W-1:0]   min_speed,
    output dsm_pkg::motor_cmd_t           cmd
);

    localparam int STAGES = 4;
    // floor(w/100) as (w*RECIP_100) >> RECIP_SH, exact for w up to 2300
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;
    localparam int          FRAC_W    = 12;
    localparam int          FRAC_P_W  = 25;

    logic [STAGES-1:0] vld_reg;

    // stage 1: signed mix, remap decision and remap product
    logic [dsm_pkg::LEVEL_W-1:0]        span;
    logic signed [dsm_pkg::QUO_W:0]     m1_reg, m1_next;
    logic                               remap1_reg, remap1_next;
    logic [dsm_pkg::REMAP_P_W-1:0]      p1_reg, p1_next;

    always_comb
    begin
        span        = 10'(dsm_pkg::DUTY_MAX) - min_speed;
        m1_next     = mix.neg ? -$signed({1'b0, mix.quo}) : $signed({1'b0, mix.quo});
        remap1_next = !mix.neg && ({2'b0, mix.quo} > move_threshold);
        p1_next     = {{dsm_pkg::LEVEL_W{1'b0}}, mix.quo}
                      * {{dsm_pkg::QUO_W{1'b0}}, span};
    end

    // stage 2: product over DUTY_MAX by shift and one correction, then offset
    logic [dsm_pkg::QUO_W-1:0]          q0, q_fix;
    logic [dsm_pkg::LEVEL_W:0]          r0;
    logic signed [dsm_pkg::MIX_W-1:0]   m2_reg, m2_next;

    always_comb
    begin
        q0    = p1_reg[dsm_pkg::REMAP_P_W-1:dsm_pkg::LEVEL_W];
        r0    = {1'b0, p1_reg[dsm_pkg::LEVEL_W-1:0]} + {3'b0, q0};
        q_fix = (r0 >= 11'(dsm_pkg::DUTY_MAX)) ? q0 + 8'd1 : q0;
        if (remap1_reg)
        begin
            m2_next = $signed({2'b0, min_speed} + {4'b0, q_fix});
        end
        else
        begin
            m2_next = {{(dsm_pkg::MIX_W-dsm_pkg::QUO_W-1){m1_reg[dsm_pkg::QUO_W]}}, m1_reg};
        end
    end

    // stage 3: direction, magnitude and the two scaled parts
    logic [dsm_pkg::MIX_W-1:0]          abs_m;
    logic [dsm_pkg::MAG_W-1:0]          mag;
    logic                               rev3_reg, sat3_reg;
    logic [FRAC_W-1:0]                  w3_reg, w3_next;
    logic [dsm_pkg::MAG_W-1:0]          tens3_reg, tens3_next;

    always_comb
    begin
        abs_m      = m2_reg[dsm_pkg::MIX_W-1] ? 12'(-m2_reg) : 12'(m2_reg);
        mag        = abs_m[dsm_pkg::MAG_W-1:0];
        // |m|*1023/100 = 10*|m| + floor(23*|m|/100)
        w3_next    = {5'b0, mag[6:0]} * 12'd23;
        tens3_next = {4'b0, mag[6:0]} * 11'd10;
    end

    // stage 4: final duty with saturation
    logic [FRAC_P_W-1:0]                frac_p;
    logic [dsm_pkg::MAG_W-1:0]          duty_sum;
    logic                               rev4_reg;
    logic [dsm_pkg::DUTY_W-1:0]         duty4_reg, duty4_next;

    always_comb
    begin
        frac_p   = {{(FRAC_P_W-FRAC_W){1'b0}}, w3_reg} * {12'b0, RECIP_100};
        duty_sum = tens3_reg + {5'b0, frac_p[FRAC_P_W-1:RECIP_SH]};
        if (sat3_reg)
        begin
            duty4_next = 10'(dsm_pkg::DUTY_MAX);
        end
        else
        begin
            duty4_next = duty_sum[dsm_pkg::DUTY_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], mix.valid};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        m1_reg     <= m1_next;
        remap1_reg <= remap1_next;
        p1_reg     <= p1_next;

        m2_reg     <= m2_next;

        rev3_reg   <= m2_reg[dsm_pkg::MIX_W-1];
        sat3_reg   <= (mag >= dsm_pkg::SAT_MAG);
        w3_reg     <= w3_next;
        tens3_reg  <= tens3_next;

        rev4_reg   <= rev3_reg;
        duty4_reg  <= duty4_next;
    end

    always_comb
    begin
        cmd.valid   = vld_reg[STAGES-1];
        cmd.reverse = rev4_reg;
        cmd.duty    = duty4_reg;
    end

endmodule

/* src/differential_steering_mixer_top.sv */
// ----------------------------------------------------------------------------
// differential_steering_mixer_top
// Joystick sample to left and right motor commands (direction and pwm duty).
// ----------------------------------------------------------------------------
// A sample is taken on every clock edge where start is high; busy never rises,
// so one item may enter each cycle. Each item gives one result after passing
// 5 stages of blend arithmetic, 4 stages of the two-bit-per-stage divider and
// 4 stages of remap and duty scaling, shown for exactly one cycle
// with done high, in the order the items entered. There is no output buffer:
// the receiver must take every result in the cycle it appears. Configuration
// writes take effect at once and should be made only while no item is in
// flight.
// ----------------------------------------------------------------------------
module differential_steering_mixer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [dsm_pkg::JOY_W-1:0]   joy_x,
    input  logic signed [dsm_pkg::JOY_W-1:0]   joy_y,
    input  logic                               cfg_we,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dsm_pkg::CFG_W-1:0]          cfg_wdata,
    output logic                               done,
    output logic                               left_reverse,
    output logic [dsm_pkg::DUTY_W-1:0]         left_duty,
    output logic                               right_reverse,
    output logic [dsm_pkg::DUTY_W-1:0]         right_duty
);

    logic [dsm_pkg::LIMIT_W-1:0]  pivot_limit_reg;
    logic [dsm_pkg::LEVEL_W-1:0]  move_threshold_reg;
    logic [dsm_pkg::LEVEL_W-1:0]  min_speed_reg;

    dsm_pkg::div_req_t    left_req, right_req;
    dsm_pkg::div_rsp_t    left_mix, right_mix;
    dsm_pkg::motor_cmd_t  left_cmd, right_cmd;

    // the pipeline takes an item every cycle
    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_limit_reg    <= dsm_pkg::PIVOT_LIMIT_RST;
            move_threshold_reg <= dsm_pkg::MOVE_THRESHOLD_RST;
            min_speed_reg      <= dsm_pkg::MIN_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (dsm_pkg::cfg_index_t'(cfg_index))
                dsm_pkg::CFG_PIVOT_LIMIT:
                begin
                    pivot_limit_reg <= cfg_wdata[dsm_pkg::LIMIT_W-1:0];
                end
                dsm_pkg::CFG_MOVE_THRESHOLD:
                begin
                    move_threshold_reg <= cfg_wdata[dsm_pkg::LEVEL_W-1:0];
                end
                dsm_pkg::CFG_MIN_SPEED:
                begin
                    min_speed_reg <= cfg_wdata[dsm_pkg::LEVEL_W-1:0];
                end
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // premix and blend numerators
    dsm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start & ~busy),
        .joy_x       (joy_x),
        .joy_y       (joy_y),
        .pivot_limit (pivot_limit_reg),
        .left_req    (left_req),
        .right_req   (right_req)
    );

    // blend quotients
    dsm_divider u_div_left (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (left_req),
        .rsp   (left_mix)
    );

    dsm_divider u_div_right (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (right_req),
        .rsp   (right_mix)
    );

    // remap and duty per side
    dsm_shaper u_shape_left (
        .clk            (clk),
        .rst_n          (rst_n),
        .mix            (left_mix),
        .move_threshold (move_threshold_reg),
        .min_speed      (min_speed_reg),
        .cmd            (left_cmd)
    );

    dsm_shaper u_shape_right (
        .clk            (clk),
        .rst_n          (rst_n),
        .mix            (right_mix),
        .move_threshold (move_threshold_reg),
        .min_speed      (min_speed_reg),
        .cmd            (right_cmd)
    );

    // result item, both sides travel in lockstep
    assign done          = left_cmd.valid & right_cmd.valid;
    assign left_reverse  = left_cmd.reverse;
    assign left_duty     = left_cmd.duty;
    assign right_reverse = right_cmd.reverse;
    assign right_duty    = right_cmd.duty;

endmodule
